@@ rtl/gvi_pkg.sv @@
// Shared types, constants and helper functions of the gravity Verlet integrator.
// No dependencies; every other file but gvi_if imports this package.
package gvi_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int CFG_IDX_W = 4;

    // Unit sizes.
    localparam int DIV_NUM_W = 72;
    localparam int DIV_DEN_W = 66;
    localparam int SQRT_IN_W = 66;
    localparam int SQRT_OUT_W = 33;
    localparam int CORDIC_STEPS = 30;
    localparam int ANG_W = 36;
    localparam int CS_W = 34;

    localparam logic [32:0] GRAV_GAIN = 33'd50;

    // Angles in Q2.30 radians.
    localparam logic signed [ANG_W-1:0] ANG_PI = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 36'sd1686629713;
    localparam logic signed [CS_W-1:0] CORDIC_K = 34'sd652032874;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BODY_MASS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRUST_POWER = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRUST_GAIN = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_ANGLE = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_X = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_VX = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_START_VY = 4'd7;

    typedef enum logic [1:0] {
        CMD_ACCUM   = 2'd0,
        CMD_STEP    = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_DIFF, OP_MUL_X, OP_MUL_Y, OP_SUM_S, OP_MUL_GM,
        OP_START_G, OP_CLIP_G, OP_MUL_GD, OP_START_F, OP_ACC_F, OP_INT_START,
        OP_CLIP_T, OP_MUL_H, OP_CLIP_H, OP_MUL_TH, OP_NET, OP_START_Q, OP_AN,
        OP_MUL_P1, OP_CLIP_P1, OP_MUL_P2, OP_CLIP_P2, OP_MUL_V, OP_UPDATE,
        OP_RESTART, OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic lane;
    } t_ctl;

    typedef struct packed {
        logic zero;
        logic div_busy;
        logic sqrt_busy;
        logic cordic_busy;
    } t_sts;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] attractor_x;
        logic signed [31:0] attractor_y;
        logic [31:0]        attractor_mass;
        logic [23:0]        time_step;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] pos_x_out;
        logic signed [31:0] pos_y_out;
        logic signed [31:0] vel_x_out;
        logic signed [31:0] vel_y_out;
        logic               zero_distance;
        logic               saturated;
    } t_out_beat;

    typedef struct packed {
        logic [31:0] val;
        logic        clipped;
    } t_clip;

    // Clip a magnitude to the word range and apply the sign.
    function automatic t_clip clip_mag(input logic [71:0] m, input logic neg);
        t_clip       r;
        logic [71:0] lim;
        logic [31:0] v;
        lim = neg ? 72'h8000_0000 : 72'h7FFF_FFFF;
        r.clipped = (m > lim);
        v = r.clipped ? lim[31:0] : m[31:0];
        r.val = neg ? 32'(-v) : v;
        return r;
    endfunction

    // Clip an exact signed sum to the word range.
    function automatic t_clip sat_sum(input logic signed [35:0] v);
        t_clip r;
        if (v > 36'sh0_7FFF_FFFF) begin
            r.val = 32'h7FFF_FFFF;
            r.clipped = 1'b1;
        end else if (v < -36'sh0_8000_0000) begin
            r.val = 32'h8000_0000;
            r.clipped = 1'b1;
        end else begin
            r.val = v[31:0];
            r.clipped = 1'b0;
        end
        return r;
    endfunction

    // Arctangent of 2^-i in Q2.30.
    function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] i);
        logic signed [ANG_W-1:0] a;
        case (i)
            5'd0: a = 36'sd843314857;
            5'd1: a = 36'sd497837829;
            5'd2: a = 36'sd263043836;
            5'd3: a = 36'sd133525158;
            5'd4: a = 36'sd67021686;
            5'd5: a = 36'sd33543515;
            5'd6: a = 36'sd16775850;
            5'd7: a = 36'sd8388437;
            5'd8: a = 36'sd4194282;
            5'd9: a = 36'sd2097149;
            5'd10: a = 36'sd1048575;
            5'd11: a = 36'sd524287;
            5'd12: a = 36'sd262143;
            5'd13: a = 36'sd131071;
            5'd14: a = 36'sd65535;
            5'd15: a = 36'sd32767;
            5'd16: a = 36'sd16383;
            5'd17: a = 36'sd8191;
            5'd18: a = 36'sd4095;
            5'd19: a = 36'sd2047;
            5'd20: a = 36'sd1023;
            5'd21: a = 36'sd511;
            5'd22: a = 36'sd255;
            5'd23: a = 36'sd127;
            5'd24: a = 36'sd63;
            5'd25: a = 36'sd31;
            5'd26: a = 36'sd15;
            5'd27: a = 36'sd8;
            5'd28: a = 36'sd4;
            5'd29: a = 36'sd2;
            default: a = 36'sd0;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/gvi_if.sv @@
// Stream interfaces for the input and result channels of the integrator.
// Does not import gvi_pkg; its field widths match the beat structs there.
interface gvi_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] attractor_x;
    logic signed [31:0] attractor_y;
    logic [31:0]        attractor_mass;
    logic [23:0]        time_step;

    modport source (output valid, command, attractor_x, attractor_y, attractor_mass,
                    time_step, input ready);
    modport sink (input valid, command, attractor_x, attractor_y, attractor_mass,
                  time_step, output ready);
endinterface

interface gvi_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic signed [31:0] vel_x_out;
    logic signed [31:0] vel_y_out;
    logic               zero_distance;
    logic               saturated;

    modport source (output valid, pos_x_out, pos_y_out, vel_x_out, vel_y_out,
                    zero_distance, saturated, input ready);
    modport sink (input valid, pos_x_out, pos_y_out, vel_x_out, vel_y_out,
                  zero_distance, saturated, output ready);
endinterface

@@ rtl/gravity_verlet_integrator_unit.sv @@
// One body under inverse-square attraction, stepped by velocity Verlet in Q16.16.
// An item takes one beat at a time: accumulate runs a division alongside a
// square root, then two more divisions; integrate runs two divisions by the
// body mass, after a CORDIC; restart and the unused command use none of them.
// A finished result waits in the output register while the next beat is
// taken. Depends on gvi_pkg, gvi_if, gvi_control and gvi_datapath.
module gravity_verlet_integrator_unit import gvi_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    gvi_in_if.sink               i_in,
    gvi_out_if.source            o_out
);
    t_ctl      ctl;
    t_sts      sts;
    t_in_beat  in_beat;
    t_out_beat out_beat;
    logic      in_ready;
    logic      out_valid;

    // Gather the input beat.
    assign in_beat.command = i_in.command;
    assign in_beat.attractor_x = i_in.attractor_x;
    assign in_beat.attractor_y = i_in.attractor_y;
    assign in_beat.attractor_mass = i_in.attractor_mass;
    assign in_beat.time_step = i_in.time_step;

    gvi_control u_control (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_cmd    (i_in.command),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_ctl       (ctl)
    );

    gvi_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (ctl),
        .i_beat     (in_beat),
        .o_sts      (sts),
        .o_beat     (out_beat)
    );

    // Drive the result beat.
    assign i_in.ready = in_ready;
    assign o_out.valid = out_valid;
    assign o_out.pos_x_out = out_beat.pos_x_out;
    assign o_out.pos_y_out = out_beat.pos_y_out;
    assign o_out.vel_x_out = out_beat.vel_x_out;
    assign o_out.vel_y_out = out_beat.vel_y_out;
    assign o_out.zero_distance = out_beat.zero_distance;
    assign o_out.saturated = out_beat.saturated;
endmodule

@@ rtl/gvi_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gvi_pkg for its widths.
module gvi_divider import gvi_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_busy,
    output logic [DIV_NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_NUM_W-1:0] r_quot;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;

    logic [DIV_DEN_W:0]   rem_sh;
    logic                 fits;

    // Shift in the next numerator bit and try the subtraction.
    assign rem_sh = {r_rem, r_num[DIV_NUM_W-1]};
    assign fits = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= '0;
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_NUM_W-2:0], 1'b0};
            r_quot <= {r_quot[DIV_NUM_W-2:0], fits};
            r_rem <= fits ? DIV_DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DIV_DEN_W-1:0];
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DIV_NUM_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quot;
endmodule

@@ rtl/gvi_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on gvi_pkg for its widths.
module gvi_sqrt import gvi_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [SQRT_IN_W-1:0]  i_src,
    output logic                  o_busy,
    output logic [SQRT_OUT_W-1:0] o_root
);
    localparam int REM_W = SQRT_OUT_W + 3;
    localparam int CNT_W = $clog2(SQRT_OUT_W);

    logic [SQRT_IN_W-1:0]  r_src;
    logic [REM_W-1:0]      r_rem;
    logic [SQRT_OUT_W-1:0] r_root;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;

    logic [REM_W+1:0]      rem_sh;
    logic [REM_W+1:0]      trial;
    logic                  fits;

    // Bring down two bits and compare against 4*root+1.
    assign rem_sh = {r_rem, r_src[SQRT_IN_W-1 -: 2]};
    assign trial = (REM_W+2)'({r_root, 2'b01});
    assign fits = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= '0;
            r_src <= i_src;
            r_rem <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_src <= {r_src[SQRT_IN_W-3:0], 2'b00};
            r_rem <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            r_root <= {r_root[SQRT_OUT_W-2:0], fits};
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(SQRT_OUT_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;
endmodule

@@ rtl/gvi_cordic.sv @@
// Iterative rotation-mode CORDIC giving cosine and sine in Q2.30.
// Depends on gvi_pkg for the angle constants and the arctangent table.
module gvi_cordic import gvi_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [18:0]     i_angle,
    output logic                   o_busy,
    output logic signed [CS_W-1:0] o_cos,
    output logic signed [CS_W-1:0] o_sin
);
    logic signed [ANG_W-1:0] r_z;
    logic signed [CS_W-1:0]  r_x;
    logic signed [CS_W-1:0]  r_y;
    logic [4:0]              r_i;
    logic                    r_flip;
    logic                    r_busy;

    logic signed [ANG_W-1:0] z_in;
    logic signed [ANG_W-1:0] z_red;
    logic                    flip_in;
    logic signed [CS_W-1:0]  dx;
    logic signed [CS_W-1:0]  dy;
    logic signed [ANG_W-1:0] atan_i;

    // Scale the Q16.16 angle to Q2.30, wrap into +-pi and fold into +-pi/2.
    always_comb begin
        z_in = {{3{i_angle[18]}}, i_angle, 14'b0};
        z_red = z_in;
        flip_in = 1'b0;
        if (z_red > ANG_PI) begin
            z_red = z_red - ANG_TWO_PI;
        end
        if (z_red < -ANG_PI) begin
            z_red = z_red + ANG_TWO_PI;
        end
        if (z_red > ANG_HALF_PI) begin
            z_red = z_red - ANG_PI;
            flip_in = 1'b1;
        end else if (z_red < -ANG_HALF_PI) begin
            z_red = z_red + ANG_PI;
            flip_in = 1'b1;
        end
    end

    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;
    assign atan_i = atan_q30(r_i);

    // One micro-rotation per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_i <= '0;
            r_z <= z_red;
            r_flip <= flip_in;
            r_x <= CORDIC_K;
            r_y <= '0;
        end else if (r_busy) begin
            if (!r_z[ANG_W-1]) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - atan_i;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + atan_i;
            end
            r_i <= r_i + 1'b1;
            if (r_i == 5'(CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_cos = r_flip ? -r_x : r_x;
    assign o_sin = r_flip ? -r_y : r_y;
endmodule

@@ rtl/gvi_datapath.sv @@
// Datapath: body state, configuration, shared multiplier and the iterative units.
// Depends on gvi_pkg, gvi_divider, gvi_sqrt and gvi_cordic.
module gvi_datapath import gvi_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  t_ctl                 i_ctl,
    input  t_in_beat             i_beat,
    output t_sts                 o_sts,
    output t_out_beat            o_beat
);
    // Configuration.
    logic [31:0]        r_mass;
    logic [31:0]        r_power;
    logic [31:0]        r_gain;
    logic signed [18:0] r_tilt;
    logic signed [31:0] r_start_x;
    logic signed [31:0] r_start_y;
    logic signed [31:0] r_start_vx;
    logic signed [31:0] r_start_vy;

    // Body state, one entry per axis.
    logic signed [31:0] r_pos [2];
    logic signed [31:0] r_vel [2];
    logic signed [31:0] r_acc [2];
    logic signed [31:0] r_fs [2];

    // Captured beat and working registers.
    logic signed [31:0] r_ax;
    logic signed [31:0] r_ay;
    logic [31:0]        r_am;
    logic [23:0]        r_dt;
    logic signed [32:0] r_dx;
    logic signed [32:0] r_dy;
    logic [65:0]        r_prod;
    logic [65:0]        r_s;
    logic [31:0]        r_g;
    logic [31:0]        r_t;
    logic [31:0]        r_h;
    logic signed [31:0] r_net;
    logic signed [31:0] r_an;
    logic signed [31:0] r_p1;
    logic signed [31:0] r_p2;
    logic               r_zero;
    logic               r_sat;
    t_out_beat          r_out;

    logic [32:0]        mul_a;
    logic [32:0]        mul_b;
    logic [65:0]        mul_p;

    logic signed [32:0] d_k;
    logic [32:0]        d_mag;
    logic signed [31:0] pos_k;
    logic signed [31:0] vel_k;
    logic signed [31:0] acc_k;
    logic signed [31:0] fs_k;
    logic [31:0]        vel_mag;
    logic [31:0]        acc_mag;
    logic signed [32:0] sum_av;
    logic [32:0]        av_mag;
    logic signed [CS_W-1:0] cs_k;
    logic [32:0]        cs_mag;
    logic [31:0]        net_mag;
    logic [31:0]        mass_eff;

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] div_quot;
    logic                 div_busy;
    logic                 sqrt_start;
    logic [SQRT_OUT_W-1:0] sqrt_root;
    logic                 sqrt_busy;
    logic                 cordic_start;
    logic signed [CS_W-1:0] cos_v;
    logic signed [CS_W-1:0] sin_v;
    logic                 cordic_busy;

    t_clip c_a;
    t_clip c_b;
    t_clip c_c;
    logic signed [31:0] th_v;

    // Per-axis selections.
    assign d_k = i_ctl.lane ? r_dy : r_dx;
    assign d_mag = d_k[32] ? 33'(-d_k) : 33'(d_k);
    assign pos_k = r_pos[i_ctl.lane];
    assign vel_k = r_vel[i_ctl.lane];
    assign acc_k = r_acc[i_ctl.lane];
    assign fs_k = r_fs[i_ctl.lane];
    assign vel_mag = vel_k[31] ? 32'(-vel_k) : vel_k;
    assign acc_mag = acc_k[31] ? 32'(-acc_k) : acc_k;
    assign sum_av = 33'(acc_k) + 33'(r_an);
    assign av_mag = sum_av[32] ? 33'(-sum_av) : 33'(sum_av);
    assign cs_k = i_ctl.lane ? sin_v : cos_v;
    assign cs_mag = cs_k[CS_W-1] ? 33'(-cs_k) : 33'(cs_k);
    assign net_mag = r_net[31] ? 32'(-r_net) : r_net;
    assign mass_eff = (r_mass == 32'd0) ? 32'd1 : r_mass;

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_ctl.op)
            OP_MUL_X, OP_MUL_Y: begin
                mul_a = d_mag;
                mul_b = d_mag;
            end
            OP_MUL_GM: begin
                mul_a = {1'b0, r_am};
                mul_b = GRAV_GAIN;
            end
            OP_MUL_GD: begin
                mul_a = {1'b0, r_g};
                mul_b = d_mag;
            end
            OP_INT_START: begin
                mul_a = {1'b0, r_power};
                mul_b = {1'b0, r_gain};
            end
            OP_MUL_H: begin
                mul_a = {9'b0, r_dt};
                mul_b = {9'b0, r_dt};
            end
            OP_MUL_TH: begin
                mul_a = {1'b0, r_t};
                mul_b = cs_mag;
            end
            OP_MUL_P1: begin
                mul_a = {1'b0, vel_mag};
                mul_b = {9'b0, r_dt};
            end
            OP_MUL_P2: begin
                mul_a = {1'b0, acc_mag};
                mul_b = {1'b0, r_h};
            end
            OP_MUL_V: begin
                mul_a = av_mag;
                mul_b = {9'b0, r_dt};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = 66'(mul_a) * 66'(mul_b);

    // Divider and square root launches.
    always_comb begin
        div_start = 1'b0;
        div_num = '0;
        div_den = '0;
        case (i_ctl.op)
            OP_START_G: begin
                div_start = 1'b1;
                div_num = {r_prod[39:0], 32'b0};
                div_den = r_s;
            end
            OP_START_F: begin
                div_start = 1'b1;
                div_num = DIV_NUM_W'(r_prod);
                div_den = DIV_DEN_W'(sqrt_root);
            end
            OP_START_Q: begin
                div_start = 1'b1;
                div_num = DIV_NUM_W'({net_mag, 16'b0});
                div_den = DIV_DEN_W'(mass_eff);
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign sqrt_start = (i_ctl.op == OP_START_G);
    assign cordic_start = (i_ctl.op == OP_INT_START);

    gvi_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    gvi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_src   (r_s),
        .o_busy  (sqrt_busy),
        .o_root  (sqrt_root)
    );

    gvi_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_angle (r_tilt),
        .o_busy  (cordic_busy),
        .o_cos   (cos_v),
        .o_sin   (sin_v)
    );

    // Clip and saturate terms for the operation in hand.
    always_comb begin
        c_a = '0;
        c_b = '0;
        c_c = '0;
        th_v = '0;
        case (i_ctl.op)
            OP_CLIP_G: c_a = clip_mag(div_quot, 1'b0);
            OP_ACC_F: begin
                c_a = clip_mag(div_quot, d_k[32]);
                c_b = sat_sum(36'(fs_k) + 36'($signed(c_a.val)));
            end
            OP_CLIP_T: c_a = clip_mag(72'(r_prod >> FRAC_W), 1'b0);
            OP_CLIP_H: c_a = clip_mag(72'(r_prod >> (FRAC_W + 1)), 1'b0);
            OP_NET: begin
                c_a = clip_mag(72'(r_prod >> 30), cs_k[CS_W-1]);
                th_v = $signed(c_a.val);
                c_b = sat_sum(36'(fs_k) + 36'(th_v));
            end
            OP_AN: begin
                c_a = clip_mag(div_quot, r_net[31]);
                c_b = sat_sum(36'sd0 - 36'($signed(c_a.val)));
            end
            OP_CLIP_P1: c_a = clip_mag(72'(r_prod >> FRAC_W), vel_k[31]);
            OP_CLIP_P2: c_a = clip_mag(72'(r_prod >> FRAC_W), acc_k[31]);
            OP_UPDATE: begin
                c_a = clip_mag(72'(r_prod >> (FRAC_W + 1)), sum_av[32]);
                c_b = sat_sum(36'(pos_k) + 36'(r_p1) + 36'(r_p2));
                c_c = sat_sum(36'(vel_k) + 36'($signed(c_a.val)));
            end
            default: begin
                c_a = '0;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass <= 32'd65536;
            r_power <= 32'd655360;
            r_gain <= 32'd65536;
            r_tilt <= '0;
            r_start_x <= '0;
            r_start_y <= '0;
            r_start_vx <= '0;
            r_start_vy <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BODY_MASS:    r_mass <= i_cfg_data;
                REG_THRUST_POWER: r_power <= i_cfg_data;
                REG_THRUST_GAIN:  r_gain <= i_cfg_data;
                REG_TILT_ANGLE:   r_tilt <= i_cfg_data[18:0];
                REG_START_X:      r_start_x <= i_cfg_data;
                REG_START_Y:      r_start_y <= i_cfg_data;
                REG_START_VX:     r_start_vx <= i_cfg_data;
                REG_START_VY:     r_start_vy <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Body state and flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_pos[k] <= '0;
                r_vel[k] <= '0;
                r_acc[k] <= '0;
                r_fs[k] <= '0;
            end
            r_zero <= 1'b0;
            r_sat <= 1'b0;
        end else begin
            case (i_ctl.op)
                OP_LOAD: begin
                    r_zero <= 1'b0;
                    r_sat <= 1'b0;
                end
                OP_DIFF: r_zero <= o_sts.zero;
                OP_CLIP_G, OP_CLIP_T, OP_CLIP_H, OP_CLIP_P1, OP_CLIP_P2: begin
                    r_sat <= r_sat | c_a.clipped;
                end
                OP_ACC_F: begin
                    r_fs[i_ctl.lane] <= c_b.val;
                    r_sat <= r_sat | c_a.clipped | c_b.clipped;
                end
                OP_NET, OP_AN: r_sat <= r_sat | c_a.clipped | c_b.clipped;
                OP_UPDATE: begin
                    r_pos[i_ctl.lane] <= c_b.val;
                    r_vel[i_ctl.lane] <= c_c.val;
                    r_acc[i_ctl.lane] <= r_an;
                    r_fs[i_ctl.lane] <= '0;
                    r_sat <= r_sat | c_a.clipped | c_b.clipped | c_c.clipped;
                end
                OP_RESTART: begin
                    r_pos[0] <= r_start_x;
                    r_pos[1] <= r_start_y;
                    r_vel[0] <= r_start_vx;
                    r_vel[1] <= r_start_vy;
                    for (int k = 0; k < 2; k++) begin
                        r_acc[k] <= '0;
                        r_fs[k] <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers carry payload only.
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_LOAD: begin
                r_ax <= i_beat.attractor_x;
                r_ay <= i_beat.attractor_y;
                r_am <= i_beat.attractor_mass;
                r_dt <= i_beat.time_step;
            end
            OP_DIFF: begin
                r_dx <= 33'(r_pos[0]) - 33'(r_ax);
                r_dy <= 33'(r_pos[1]) - 33'(r_ay);
            end
            OP_MUL_X, OP_MUL_GM, OP_MUL_GD, OP_INT_START, OP_MUL_H, OP_MUL_TH,
            OP_MUL_P1, OP_MUL_P2, OP_MUL_V: r_prod <= mul_p;
            OP_MUL_Y: begin
                r_s <= r_prod;
                r_prod <= mul_p;
            end
            OP_SUM_S: r_s <= r_s + r_prod;
            OP_CLIP_G: r_g <= c_a.val;
            OP_CLIP_T: r_t <= c_a.val;
            OP_CLIP_H: r_h <= c_a.val;
            OP_NET: r_net <= c_b.val;
            OP_AN: r_an <= c_b.val;
            OP_CLIP_P1: r_p1 <= c_a.val;
            OP_CLIP_P2: r_p2 <= c_a.val;
            OP_FINISH: begin
                r_out.pos_x_out <= r_pos[0];
                r_out.pos_y_out <= r_pos[1];
                r_out.vel_x_out <= r_vel[0];
                r_out.vel_y_out <= r_vel[1];
                r_out.zero_distance <= r_zero;
                r_out.saturated <= r_sat;
            end
            default: begin
            end
        endcase
    end

    // Status back to the controller.
    assign o_sts.zero = (r_pos[0] == r_ax) && (r_pos[1] == r_ay);
    assign o_sts.div_busy = div_busy;
    assign o_sts.sqrt_busy = sqrt_busy;
    assign o_sts.cordic_busy = cordic_busy;
    assign o_beat = r_out;
endmodule

@@ rtl/gvi_control.sv @@
// Controller: sequences one item through the datapath and runs both handshakes.
// Depends on gvi_pkg for the operation codes and the command/status structs.
module gvi_control import gvi_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic [1:0] i_in_cmd,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output logic o_in_ready,
    output logic o_out_valid,
    output t_ctl o_ctl
);
    typedef enum logic [30:0] {
        S_IDLE      = 31'b1 << 0,
        S_DIFF      = 31'b1 << 1,
        S_MUL_X     = 31'b1 << 2,
        S_MUL_Y     = 31'b1 << 3,
        S_SUM_S     = 31'b1 << 4,
        S_MUL_GM    = 31'b1 << 5,
        S_START_G   = 31'b1 << 6,
        S_WAIT_G    = 31'b1 << 7,
        S_CLIP_G    = 31'b1 << 8,
        S_MUL_GD    = 31'b1 << 9,
        S_START_F   = 31'b1 << 10,
        S_WAIT_F    = 31'b1 << 11,
        S_ACC_F     = 31'b1 << 12,
        S_INT_START = 31'b1 << 13,
        S_CLIP_T    = 31'b1 << 14,
        S_MUL_H     = 31'b1 << 15,
        S_CLIP_H    = 31'b1 << 16,
        S_WAIT_C    = 31'b1 << 17,
        S_MUL_TH    = 31'b1 << 18,
        S_NET       = 31'b1 << 19,
        S_START_Q   = 31'b1 << 20,
        S_WAIT_Q    = 31'b1 << 21,
        S_AN        = 31'b1 << 22,
        S_MUL_P1    = 31'b1 << 23,
        S_CLIP_P1   = 31'b1 << 24,
        S_MUL_P2    = 31'b1 << 25,
        S_CLIP_P2   = 31'b1 << 26,
        S_MUL_V     = 31'b1 << 27,
        S_UPDATE    = 31'b1 << 28,
        S_RESTART   = 31'b1 << 29,
        S_FINISH    = 31'b1 << 30
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_lane;
    logic   n_lane;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Next state and the operation for this cycle.
    always_comb begin
        n_state = r_state;
        n_lane = r_lane;
        o_ctl.op = OP_NONE;
        o_ctl.lane = r_lane;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.op = OP_LOAD;
                    n_lane = 1'b0;
                    unique case (t_cmd'(i_in_cmd))
                        CMD_ACCUM:   n_state = S_DIFF;
                        CMD_STEP:    n_state = S_INT_START;
                        CMD_RESTART: n_state = S_RESTART;
                        CMD_NOP:     n_state = S_FINISH;
                        default:     n_state = S_FINISH;
                    endcase
                end
            end
            S_DIFF: begin
                o_ctl.op = OP_DIFF;
                n_state = i_sts.zero ? S_FINISH : S_MUL_X;
            end
            S_MUL_X: begin
                o_ctl.op = OP_MUL_X;
                o_ctl.lane = 1'b0;
                n_state = S_MUL_Y;
            end
            S_MUL_Y: begin
                o_ctl.op = OP_MUL_Y;
                o_ctl.lane = 1'b1;
                n_state = S_SUM_S;
            end
            S_SUM_S: begin
                o_ctl.op = OP_SUM_S;
                n_state = S_MUL_GM;
            end
            S_MUL_GM: begin
                o_ctl.op = OP_MUL_GM;
                n_state = S_START_G;
            end
            S_START_G: begin
                o_ctl.op = OP_START_G;
                n_state = S_WAIT_G;
            end
            S_WAIT_G: begin
                if (!i_sts.div_busy && !i_sts.sqrt_busy) begin
                    n_state = S_CLIP_G;
                end
            end
            S_CLIP_G: begin
                o_ctl.op = OP_CLIP_G;
                n_state = S_MUL_GD;
            end
            S_MUL_GD: begin
                o_ctl.op = OP_MUL_GD;
                n_state = S_START_F;
            end
            S_START_F: begin
                o_ctl.op = OP_START_F;
                n_state = S_WAIT_F;
            end
            S_WAIT_F: begin
                if (!i_sts.div_busy) begin
                    n_state = S_ACC_F;
                end
            end
            S_ACC_F: begin
                o_ctl.op = OP_ACC_F;
                n_lane = 1'b1;
                n_state = r_lane ? S_FINISH : S_MUL_GD;
            end
            S_INT_START: begin
                o_ctl.op = OP_INT_START;
                n_state = S_CLIP_T;
            end
            S_CLIP_T: begin
                o_ctl.op = OP_CLIP_T;
                n_state = S_MUL_H;
            end
            S_MUL_H: begin
                o_ctl.op = OP_MUL_H;
                n_state = S_CLIP_H;
            end
            S_CLIP_H: begin
                o_ctl.op = OP_CLIP_H;
                n_state = S_WAIT_C;
            end
            S_WAIT_C: begin
                if (!i_sts.cordic_busy) begin
                    n_state = S_MUL_TH;
                end
            end
            S_MUL_TH: begin
                o_ctl.op = OP_MUL_TH;
                n_state = S_NET;
            end
            S_NET: begin
                o_ctl.op = OP_NET;
                n_state = S_START_Q;
            end
            S_START_Q: begin
                o_ctl.op = OP_START_Q;
                n_state = S_WAIT_Q;
            end
            S_WAIT_Q: begin
                if (!i_sts.div_busy) begin
                    n_state = S_AN;
                end
            end
            S_AN: begin
                o_ctl.op = OP_AN;
                n_state = S_MUL_P1;
            end
            S_MUL_P1: begin
                o_ctl.op = OP_MUL_P1;
                n_state = S_CLIP_P1;
            end
            S_CLIP_P1: begin
                o_ctl.op = OP_CLIP_P1;
                n_state = S_MUL_P2;
            end
            S_MUL_P2: begin
                o_ctl.op = OP_MUL_P2;
                n_state = S_CLIP_P2;
            end
            S_CLIP_P2: begin
                o_ctl.op = OP_CLIP_P2;
                n_state = S_MUL_V;
            end
            S_MUL_V: begin
                o_ctl.op = OP_MUL_V;
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                o_ctl.op = OP_UPDATE;
                n_lane = 1'b1;
                n_state = r_lane ? S_FINISH : S_MUL_TH;
            end
            S_RESTART: begin
                o_ctl.op = OP_RESTART;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_ctl.op = OP_FINISH;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_lane <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lane <= n_lane;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
endmodule
